### hdl/kpva_pkg.sv
package kpva_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int NREG = 8;
  localparam int IDXW = 3;

  // register indexes
  localparam logic [IDXW-1:0] REG_PQ  = 3'd0;
  localparam logic [IDXW-1:0] REG_VQ  = 3'd1;
  localparam logic [IDXW-1:0] REG_MR  = 3'd2;
  localparam logic [IDXW-1:0] REG_IP  = 3'd3;
  localparam logic [IDXW-1:0] REG_IV  = 3'd4;
  localparam logic [IDXW-1:0] REG_IPP = 3'd5;
  localparam logic [IDXW-1:0] REG_IPV = 3'd6;
  localparam logic [IDXW-1:0] REG_IVV = 3'd7;

  // datapath register file slots
  typedef enum logic [3:0] {
    R_P, R_V, R_P00, R_P01, R_P11, R_A, R_B, R_C,
    R_PP, R_VP, R_S, R_K0, R_K1, R_Y, R_T0, R_T1
  } rsel_t;

  // operand sources beyond the register slots
  typedef enum logic [2:0] {
    SRC_REG, SRC_DT, SRC_ACC, SRC_Z, SRC_PQ, SRC_VQ, SRC_MR, SRC_MUL
  } src_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_MUL, OP_ADD, OP_SUB, OP_ADD3, OP_DIV, OP_HALF
  } op_t;

  typedef struct packed {
    op_t   op;
    src_t  sa;
    rsel_t ra;
    src_t  sb;
    rsel_t rb;
    rsel_t rc;
    rsel_t rd;
    logic  wr;
    logic  commit;
    logic  latch_in;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic s_zero;
  } stat_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_OUT} state_t;

  localparam int NSTEP = 24;
  localparam int STW = 5;

endpackage

### hdl/kpva_if.sv
interface kpva_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [kpva_pkg::DW-1:0] accel_in;
  logic signed [kpva_pkg::DW-1:0] meas_position;
  logic [23:0]                  step_time;
  modport source (output valid, accel_in, meas_position, step_time, input ready);
  modport sink (input valid, accel_in, meas_position, step_time, output ready);
endinterface

interface kpva_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [kpva_pkg::DW-1:0] est_position;
  logic signed [kpva_pkg::DW-1:0] est_velocity;
  logic                         singular_flag;
  modport source (output valid, est_position, est_velocity, singular_flag, input ready);
  modport sink (input valid, est_position, est_velocity, singular_flag, output ready);
endinterface

### hdl/kpva_div.sv
module kpva_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [kpva_pkg::DW-1:0]  num,
  input  logic signed [kpva_pkg::DW-1:0]  den,
  output logic                            busy,
  output logic signed [kpva_pkg::DW-1:0]  quo
);
  localparam int NW = kpva_pkg::DW + kpva_pkg::FB;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [NW:0] QMAX = (NW + 1)'((64'(1) << (kpva_pkg::DW - 1)) - 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [kpva_pkg::DW:0] rem_r, rem_nxt;
  logic [kpva_pkg::DW-1:0] d_r, d_nxt;
  logic neg_r, neg_nxt, busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [kpva_pkg::DW:0] trial;
  logic signed [NW:0] sq;

  // restoring division of magnitudes, one quotient bit per cycle
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    busy_nxt = busy_r; cnt_nxt = cnt_r;
    trial = {rem_r[kpva_pkg::DW-1:0], q_r[NW-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = {(num[kpva_pkg::DW-1] ? kpva_pkg::DW'(-num) : kpva_pkg::DW'(num)),
               kpva_pkg::FB'(0)};
      d_nxt = den[kpva_pkg::DW-1] ? kpva_pkg::DW'(-den) : kpva_pkg::DW'(den);
      neg_nxt = num[kpva_pkg::DW-1] ^ den[kpva_pkg::DW-1];
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[kpva_pkg::DW]) begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[kpva_pkg::DW-1:0], q_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  // sign and saturate
  always_comb begin
    sq = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    if (sq > QMAX) quo = QMAX[kpva_pkg::DW-1:0];
    else if (sq < -QMAX - 1) quo = {1'b1, {(kpva_pkg::DW-1){1'b0}}};
    else quo = sq[kpva_pkg::DW-1:0];
  end
  assign busy = busy_r;
endmodule

### hdl/kpva_datapath.sv
module kpva_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kpva_pkg::cmd_t                  cmd,
  output kpva_pkg::stat_t                 stat,
  input  logic                            cfg_we,
  input  logic [kpva_pkg::IDXW-1:0]       cfg_idx,
  input  logic [kpva_pkg::DW-1:0]         cfg_data,
  input  logic signed [kpva_pkg::DW-1:0]  accel_in,
  input  logic signed [kpva_pkg::DW-1:0]  meas_position,
  input  logic [23:0]                     step_time,
  output logic signed [kpva_pkg::DW-1:0]  est_position,
  output logic signed [kpva_pkg::DW-1:0]  est_velocity
);
  localparam int W = kpva_pkg::DW;
  localparam int EW = W + 3;
  localparam logic signed [EW-1:0] HI = EW'((64'(1) << (W - 1)) - 1);
  localparam logic signed [EW-1:0] LO = -HI - EW'(1);
  localparam logic signed [2*W-1:0] MHI = (2*W)'(HI);
  localparam logic signed [2*W-1:0] MLO = (2*W)'(LO);

  logic signed [W-1:0] rf_r [16];
  logic signed [W-1:0] acc_r, z_r, dt_r, mul_r;
  logic [30:0] pq_r, vq_r, mr_r;
  logic signed [W-1:0] opa, opb, opc, res;
  logic signed [2*W-1:0] prod, prods;
  logic signed [EW-1:0] sum;
  logic dstart, dbusy;
  logic signed [W-1:0] dquo;

  function automatic logic signed [W-1:0] pick(kpva_pkg::src_t s,
      logic signed [W-1:0] rv, logic signed [W-1:0] dt, logic signed [W-1:0] a,
      logic signed [W-1:0] z, logic [30:0] pq, logic [30:0] vq, logic [30:0] mr,
      logic signed [W-1:0] m);
    logic signed [W-1:0] o;
    unique case (s)
      kpva_pkg::SRC_DT:  o = dt;
      kpva_pkg::SRC_ACC: o = a;
      kpva_pkg::SRC_Z:   o = z;
      kpva_pkg::SRC_PQ:  o = {1'b0, pq};
      kpva_pkg::SRC_VQ:  o = {1'b0, vq};
      kpva_pkg::SRC_MR:  o = {1'b0, mr};
      kpva_pkg::SRC_MUL: o = m;
      default:           o = rv;
    endcase
    return o;
  endfunction

  always_comb begin
    opa = pick(cmd.sa, rf_r[cmd.ra], dt_r, acc_r, z_r, pq_r, vq_r, mr_r, mul_r);
    opb = pick(cmd.sb, rf_r[cmd.rb], dt_r, acc_r, z_r, pq_r, vq_r, mr_r, mul_r);
    opc = rf_r[cmd.rc];
    prod = opa * opb;
    prods = prod >>> kpva_pkg::FB;
    sum = '0;
    res = '0;
    unique case (cmd.op)
      kpva_pkg::OP_MUL: begin
        if (prods > MHI) res = HI[W-1:0];
        else if (prods < MLO) res = LO[W-1:0];
        else res = prods[W-1:0];
      end
      kpva_pkg::OP_ADD:  sum = EW'(opa) + EW'(opb);
      kpva_pkg::OP_SUB:  sum = EW'(opa) - EW'(opb);
      // a + 2b + c plus the position noise, one saturation at the end
      kpva_pkg::OP_ADD3: sum = EW'(opa) + (EW'(opb) <<< 1) + EW'(opc) +
                               EW'($signed({1'b0, pq_r}));
      kpva_pkg::OP_DIV:  res = dquo;
      kpva_pkg::OP_HALF: sum = EW'(opa) + EW'(opb) + (EW'(opc) >>> 1);
      default: ;
    endcase
    if (cmd.op == kpva_pkg::OP_ADD || cmd.op == kpva_pkg::OP_SUB ||
        cmd.op == kpva_pkg::OP_ADD3 || cmd.op == kpva_pkg::OP_HALF) begin
      if (sum > HI) res = HI[W-1:0];
      else if (sum < LO) res = LO[W-1:0];
      else res = sum[W-1:0];
    end
  end

  assign dstart = cmd.op == kpva_pkg::OP_DIV && cmd.wr == 1'b0;

  kpva_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(opa), .den(opb),
    .busy(dbusy), .quo(dquo)
  );

  // register file, configuration and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pq_r <= 31'd655; vq_r <= 31'd6554; mr_r <= '0;
      rf_r[kpva_pkg::R_P] <= '0; rf_r[kpva_pkg::R_V] <= '0;
      rf_r[kpva_pkg::R_P00] <= '0; rf_r[kpva_pkg::R_P01] <= '0;
      rf_r[kpva_pkg::R_P11] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          kpva_pkg::REG_PQ:  pq_r <= cfg_data[30:0];
          kpva_pkg::REG_VQ:  vq_r <= cfg_data[30:0];
          kpva_pkg::REG_MR:  mr_r <= cfg_data[30:0];
          kpva_pkg::REG_IP:  rf_r[kpva_pkg::R_P] <= cfg_data;
          kpva_pkg::REG_IV:  rf_r[kpva_pkg::R_V] <= cfg_data;
          kpva_pkg::REG_IPP: rf_r[kpva_pkg::R_P00] <= {1'b0, cfg_data[30:0]};
          kpva_pkg::REG_IPV: rf_r[kpva_pkg::R_P01] <= cfg_data;
          kpva_pkg::REG_IVV: rf_r[kpva_pkg::R_P11] <= {1'b0, cfg_data[30:0]};
          default: ;
        endcase
      end
      if (cmd.wr && cmd.rd <= kpva_pkg::R_P11) rf_r[cmd.rd] <= res;
      if (cmd.commit) begin
        rf_r[kpva_pkg::R_P] <= rf_r[kpva_pkg::R_PP];
        rf_r[kpva_pkg::R_V] <= rf_r[kpva_pkg::R_VP];
        rf_r[kpva_pkg::R_P00] <= rf_r[kpva_pkg::R_A];
        rf_r[kpva_pkg::R_P01] <= rf_r[kpva_pkg::R_B];
        rf_r[kpva_pkg::R_P11] <= rf_r[kpva_pkg::R_C];
      end
    end
    if (cmd.wr && cmd.rd > kpva_pkg::R_P11) rf_r[cmd.rd] <= res;
    if (cmd.op == kpva_pkg::OP_MUL) mul_r <= res;
    if (cmd.latch_in) begin
      acc_r <= accel_in; z_r <= meas_position; dt_r <= {8'd0, step_time};
    end
  end

  assign stat.busy = dbusy;
  assign stat.s_zero = rf_r[kpva_pkg::R_S] == '0;
  assign est_position = rf_r[kpva_pkg::R_P];
  assign est_velocity = rf_r[kpva_pkg::R_V];
endmodule

### hdl/kpva_ctrl.sv
module kpva_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              out_fire,
  input  kpva_pkg::stat_t   stat,
  output kpva_pkg::cmd_t    cmd,
  output logic              in_rdy,
  output logic              out_vld,
  output logic              sing
);
  kpva_pkg::state_t st_r, st_nxt;
  logic [kpva_pkg::STW-1:0] pc_r, pc_nxt;
  logic sing_r, sing_nxt;
  kpva_pkg::cmd_t mc;

  localparam kpva_pkg::rsel_t X = kpva_pkg::R_T0;

  function automatic kpva_pkg::cmd_t mk(kpva_pkg::op_t op, kpva_pkg::src_t sa,
      kpva_pkg::rsel_t ra, kpva_pkg::src_t sb, kpva_pkg::rsel_t rb,
      kpva_pkg::rsel_t rc, kpva_pkg::rsel_t rd, logic wr);
    kpva_pkg::cmd_t c;
    c.op = op; c.sa = sa; c.ra = ra; c.sb = sb; c.rb = rb; c.rc = rc; c.rd = rd;
    c.wr = wr; c.commit = 1'b0; c.latch_in = 1'b0;
    return c;
  endfunction

  // step program: one shared multiplier, adder or divider operation per cycle, holding while the divider is busy
  always_comb begin
    unique case (pc_r)
      5'd0:  mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_DT, X, kpva_pkg::SRC_ACC, X,
                     X, kpva_pkg::R_T0, 1'b1);
      5'd1:  mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_DT, X, kpva_pkg::SRC_MUL, X,
                     X, kpva_pkg::R_T1, 1'b1);
      5'd2:  mc = mk(kpva_pkg::OP_ADD, kpva_pkg::SRC_REG, kpva_pkg::R_V,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, X, kpva_pkg::R_VP, 1'b1);
      5'd3:  mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_DT, X, kpva_pkg::SRC_REG,
                     kpva_pkg::R_V, X, kpva_pkg::R_T0, 1'b1);
      5'd4:  mc = mk(kpva_pkg::OP_HALF, kpva_pkg::SRC_REG, kpva_pkg::R_P,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, kpva_pkg::R_T1,
                     kpva_pkg::R_PP, 1'b1);
      5'd5:  mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_DT, X, kpva_pkg::SRC_REG,
                     kpva_pkg::R_P11, X, kpva_pkg::R_T0, 1'b1);
      5'd6:  mc = mk(kpva_pkg::OP_ADD, kpva_pkg::SRC_REG, kpva_pkg::R_P01,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, X, kpva_pkg::R_B, 1'b1);
      5'd7:  mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_DT, X, kpva_pkg::SRC_REG,
                     kpva_pkg::R_T0, X, kpva_pkg::R_T1, 1'b1);
      5'd8:  mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_DT, X, kpva_pkg::SRC_REG,
                     kpva_pkg::R_P01, X, kpva_pkg::R_T0, 1'b1);
      // P00 + 2m + m2 + q, exact in the wide sum
      5'd9:  mc = mk(kpva_pkg::OP_ADD3, kpva_pkg::SRC_REG, kpva_pkg::R_P00,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, kpva_pkg::R_T1,
                     kpva_pkg::R_A, 1'b1);
      5'd10: mc = mk(kpva_pkg::OP_NONE, kpva_pkg::SRC_REG, X, kpva_pkg::SRC_REG, X,
                     X, X, 1'b0);
      5'd11: mc = mk(kpva_pkg::OP_ADD, kpva_pkg::SRC_REG, kpva_pkg::R_P11,
                     kpva_pkg::SRC_VQ, X, X, kpva_pkg::R_C, 1'b1);
      5'd12: mc = mk(kpva_pkg::OP_ADD, kpva_pkg::SRC_REG, kpva_pkg::R_A,
                     kpva_pkg::SRC_MR, X, X, kpva_pkg::R_S, 1'b1);
      5'd13: mc = mk(kpva_pkg::OP_DIV, kpva_pkg::SRC_REG, kpva_pkg::R_A,
                     kpva_pkg::SRC_REG, kpva_pkg::R_S, X, X, 1'b0);
      5'd14: mc = mk(kpva_pkg::OP_DIV, kpva_pkg::SRC_REG, kpva_pkg::R_A,
                     kpva_pkg::SRC_REG, kpva_pkg::R_S, X, kpva_pkg::R_K0, 1'b1);
      5'd15: mc = mk(kpva_pkg::OP_DIV, kpva_pkg::SRC_REG, kpva_pkg::R_B,
                     kpva_pkg::SRC_REG, kpva_pkg::R_S, X, X, 1'b0);
      5'd16: mc = mk(kpva_pkg::OP_DIV, kpva_pkg::SRC_REG, kpva_pkg::R_B,
                     kpva_pkg::SRC_REG, kpva_pkg::R_S, X, kpva_pkg::R_K1, 1'b1);
      5'd17: mc = mk(kpva_pkg::OP_SUB, kpva_pkg::SRC_Z, X, kpva_pkg::SRC_REG,
                     kpva_pkg::R_PP, X, kpva_pkg::R_Y, 1'b1);
      5'd18: mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_REG, kpva_pkg::R_K0,
                     kpva_pkg::SRC_REG, kpva_pkg::R_Y, X, kpva_pkg::R_T0, 1'b1);
      5'd19: mc = mk(kpva_pkg::OP_ADD, kpva_pkg::SRC_REG, kpva_pkg::R_PP,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, X, kpva_pkg::R_PP, 1'b1);
      5'd20: mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_REG, kpva_pkg::R_K1,
                     kpva_pkg::SRC_REG, kpva_pkg::R_Y, X, kpva_pkg::R_T0, 1'b1);
      5'd21: mc = mk(kpva_pkg::OP_ADD, kpva_pkg::SRC_REG, kpva_pkg::R_VP,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, X, kpva_pkg::R_VP, 1'b1);
      5'd22: mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_REG, kpva_pkg::R_K1,
                     kpva_pkg::SRC_REG, kpva_pkg::R_B, X, kpva_pkg::R_T0, 1'b1);
      5'd23: mc = mk(kpva_pkg::OP_SUB, kpva_pkg::SRC_REG, kpva_pkg::R_C,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, X, kpva_pkg::R_C, 1'b1);
      5'd24: mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_REG, kpva_pkg::R_K0,
                     kpva_pkg::SRC_REG, kpva_pkg::R_B, X, kpva_pkg::R_T0, 1'b1);
      5'd25: mc = mk(kpva_pkg::OP_SUB, kpva_pkg::SRC_REG, kpva_pkg::R_B,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, X, kpva_pkg::R_B, 1'b1);
      5'd26: mc = mk(kpva_pkg::OP_MUL, kpva_pkg::SRC_REG, kpva_pkg::R_K0,
                     kpva_pkg::SRC_REG, kpva_pkg::R_A, X, kpva_pkg::R_T0, 1'b1);
      5'd27: mc = mk(kpva_pkg::OP_SUB, kpva_pkg::SRC_REG, kpva_pkg::R_A,
                     kpva_pkg::SRC_REG, kpva_pkg::R_T0, X, kpva_pkg::R_A, 1'b1);
      default: mc = mk(kpva_pkg::OP_NONE, kpva_pkg::SRC_REG, X, kpva_pkg::SRC_REG, X,
                       X, X, 1'b0);
    endcase
  end

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; sing_nxt = sing_r;
    cmd = mk(kpva_pkg::OP_NONE, kpva_pkg::SRC_REG, X, kpva_pkg::SRC_REG, X, X, X, 1'b0);
    in_rdy = 1'b0; out_vld = 1'b0;
    unique case (st_r)
      kpva_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        cmd.latch_in = in_fire;
        if (in_fire) begin
          st_nxt = kpva_pkg::ST_RUN; pc_nxt = '0;
        end
      end
      kpva_pkg::ST_RUN: begin
        cmd = mc;
        if (pc_r == 5'd13 || pc_r == 5'd15) begin
          st_nxt = kpva_pkg::ST_WAIT;
          pc_nxt = pc_r + 5'd1;
        end else if (pc_r == 5'd27) begin
          cmd.commit = 1'b0;
          st_nxt = kpva_pkg::ST_OUT; sing_nxt = 1'b0;
          pc_nxt = 5'd28;
        end else begin
          pc_nxt = pc_r + 5'd1;
        end
        // zero innovation variance: skip the correction
        if (pc_r == 5'd13 && stat.s_zero) begin
          cmd.op = kpva_pkg::OP_NONE;
          st_nxt = kpva_pkg::ST_OUT; sing_nxt = 1'b1; pc_nxt = 5'd28;
        end
      end
      kpva_pkg::ST_WAIT: begin
        if (!stat.busy) begin
          cmd = mc;
          st_nxt = kpva_pkg::ST_RUN;
          pc_nxt = pc_r + 5'd1;
        end
      end
      kpva_pkg::ST_OUT: begin
        // this state first commits the new state, then the item is shown
        if (pc_r == 5'd28) begin
          cmd.commit = 1'b1;
          pc_nxt = 5'd29;
        end else begin
          out_vld = 1'b1;
          if (out_fire) st_nxt = kpva_pkg::ST_IDLE;
        end
      end
      default: st_nxt = kpva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kpva_pkg::ST_IDLE; pc_r <= '0; sing_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; sing_r <= sing_nxt;
    end
  end
  assign sing = sing_r;
endmodule

### hdl/kalman_pos_vel_accel_input_unit.sv
// channel | dir | handshake       | payload
// in      | in  | valid/ready     | accel_in, meas_position, step_time
// out     | out | valid/ready     | est_position, est_velocity, singular_flag
// cfg     | in  | cfg_we          | cfg_idx, cfg_data
// An item runs from acceptance through the program steps, two divider passes
// (start, 48 quotient bits, readout), the commit of the new state and the result,
// then back to the idle state that takes the next item.
// A zero innovation variance skips both divider passes.
// Reset loads the register reset values into the filter state.
// A waiting result holds the unit while the output stalls; input only when idle.
module kalman_pos_vel_accel_input_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  kpva_in_if.sink                   in_ch,
  kpva_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [kpva_pkg::IDXW-1:0] cfg_idx,
  input  logic [kpva_pkg::DW-1:0]   cfg_data
);
  kpva_pkg::cmd_t  cmd;
  kpva_pkg::stat_t stat;
  logic in_fire, out_fire;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  kpva_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
    .stat(stat), .cmd(cmd), .in_rdy(in_ch.ready), .out_vld(out_ch.valid),
    .sing(out_ch.singular_flag)
  );

  kpva_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .accel_in(in_ch.accel_in), .meas_position(in_ch.meas_position),
    .step_time(in_ch.step_time),
    .est_position(out_ch.est_position), .est_velocity(out_ch.est_velocity)
  );

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.est_position))
    else $error("result changed while stalled");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> in_ch.ready) else $error("not idle after result");
`endif
endmodule
